>>> sv/smsd_pkg.sv
// Shared types, constants and helper functions of the SMS user data hex decoder.
// No dependencies; the submodules, the top level and the testbench files import this package.
`timescale 1ns / 1ps

package smsd_pkg;

    // Decode modes held in the configuration register.
    typedef enum logic [1:0] {
        MODE_SEVEN = 2'd0,
        MODE_EIGHT = 2'd1,
        MODE_UCS2  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    // 'A' - 10: maps 'A'..'F' onto 10..15.
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [2:0] LAST_PHASE    = 3'd6;
    localparam logic [2:0] SEPT_BITS     = 3'd7;

    typedef struct packed {
        logic [7:0] hex_high;
        logic [7:0] hex_low;
        logic       final_octet;
    } t_in_item;

    // Up to two results of one request; the second one always closes the run.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] char0;
        logic       last0;
        logic [7:0] char1;
    } t_dec_res;

    function automatic logic [3:0] nibble_of(input logic [7:0] ch);
        logic [7:0] diff;
        begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                diff = ch - CHAR_ZERO;
            end else begin
                diff = ch - HEX_ALPHA_OFS;
            end
            nibble_of = diff[3:0];
        end
    endfunction

endpackage

>>> sv/smsd_ifs.sv
// Valid/ready channel interfaces for the decoder's input octets and output characters.
// Depends on nothing; used by the top level and its input and result stages.
`timescale 1ns / 1ps

interface smsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hex_high;
    logic [7:0] hex_low;
    logic       final_octet;

    modport source (output valid, output hex_high, output hex_low, output final_octet,
                    input ready);
    modport sink   (input valid, input hex_high, input hex_low, input final_octet,
                    output ready);
endinterface

interface smsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       run_last;

    modport source (output valid, output char_out, output run_last, input ready);
    modport sink   (input valid, input char_out, input run_last, output ready);
endinterface

>>> sv/smsd_in_reg.sv
// Input register stage: captures one request from the input channel.
// Depends on smsd_pkg and smsd_in_if.
`timescale 1ns / 1ps

module smsd_in_reg
    import smsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    smsd_in_if.sink      i_in,
    input  logic         i_fire,
    output logic         o_valid,
    output t_in_item     o_item
);

    logic     r_valid;
    t_in_item r_item;

    // The register frees up in the same cycle that its request moves on.
    assign i_in.ready = !r_valid || i_fire;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_item.hex_high    <= i_in.hex_high;
            r_item.hex_low     <= i_in.hex_low;
            r_item.final_octet <= i_in.final_octet;
        end
    end

endmodule

>>> sv/smsd_decode.sv
// Octet decoder: mode register, septet/UCS2 state and the combinational decode.
// Depends on smsd_pkg.
`timescale 1ns / 1ps

module smsd_decode
    import smsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_data,
    input  t_in_item     i_item,
    input  logic         i_fire,
    output t_dec_res     o_res
);

    t_mode       r_mode;
    logic [2:0]  r_phase;
    logic [6:0]  r_carry;
    logic [7:0]  r_held;
    logic        r_half;

    logic [2:0]  n_phase;
    logic [6:0]  n_carry;
    logic [7:0]  n_held;
    logic        n_half;

    logic [7:0]  octet;
    logic [14:0] shifted;
    logic [6:0]  sept;
    logic [7:0]  carry_out;

    always_comb begin
        octet     = {nibble_of(i_item.hex_high), nibble_of(i_item.hex_low)};
        shifted   = {7'd0, octet} << r_phase;
        sept      = shifted[6:0] | r_carry;
        carry_out = octet >> (SEPT_BITS - r_phase);

        n_phase = r_phase;
        n_carry = r_carry;
        n_held  = r_held;
        n_half  = r_half;
        o_res   = '0;

        unique case (r_mode)
            MODE_SEVEN: begin
                o_res.char0 = {1'b0, sept};
                if (r_phase == LAST_PHASE) begin
                    // Seventh octet of a group: the carried bits form one more septet.
                    o_res.count = 2'd2;
                    o_res.last0 = 1'b0;
                    o_res.char1 = {1'b0, carry_out[6:0]};
                    n_phase     = 3'd0;
                    n_carry     = 7'd0;
                end else begin
                    o_res.count = 2'd1;
                    o_res.last0 = 1'b1;
                    n_phase     = r_phase + 3'd1;
                    n_carry     = carry_out[6:0];
                end
            end
            MODE_EIGHT: begin
                o_res.count = 2'd1;
                o_res.char0 = octet;
                o_res.last0 = 1'b1;
            end
            MODE_UCS2: begin
                if (r_half) begin
                    o_res.count = 2'd2;
                    o_res.char0 = octet;
                    o_res.last0 = 1'b0;
                    o_res.char1 = r_held;
                    n_half      = 1'b0;
                end else begin
                    n_held = octet;
                    n_half = 1'b1;
                end
            end
            MODE_NONE: begin
                o_res.count = 2'd0;
            end
            default: begin
                o_res.count = 2'd0;
            end
        endcase

        if (i_item.final_octet) begin
            n_phase = 3'd0;
            n_carry = 7'd0;
            n_held  = 8'd0;
            n_half  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SEVEN;
            r_phase <= 3'd0;
            r_carry <= 7'd0;
            r_held  <= 8'd0;
            r_half  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_data);
            end
            if (i_fire) begin
                r_phase <= n_phase;
                r_carry <= n_carry;
                r_held  <= n_held;
                r_half  <= n_half;
            end
        end
    end

endmodule

>>> sv/smsd_out_stage.sv
// Result register with one pending slot for the second result of a request.
// Depends on smsd_pkg and smsd_out_if.
`timescale 1ns / 1ps

module smsd_out_stage
    import smsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_fire,
    input  t_dec_res     i_res,
    output logic         o_free,
    smsd_out_if.source   o_out
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_pend;
    logic [7:0] r_pend_char;

    // New results may load once nothing remains after the current transfer.
    assign o_free         = !r_valid || (o_out.ready && !r_pend);
    assign o_out.valid    = r_valid;
    assign o_out.char_out = r_char;
    assign o_out.run_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_fire) begin
            r_valid <= (i_res.count != 2'd0);
            r_pend  <= (i_res.count == 2'd2);
        end else if (r_valid && o_out.ready) begin
            r_valid <= r_pend;
            r_pend  <= 1'b0;
        end
        if (i_fire) begin
            r_char      <= i_res.char0;
            r_last      <= i_res.last0;
            r_pend_char <= i_res.char1;
        end else if (r_valid && o_out.ready && r_pend) begin
            r_char <= r_pend_char;
            r_last <= 1'b1;
        end
    end

endmodule

>>> sv/sms_user_data_hex_decoder.sv
// A request passes the input register and then the result register, which loads it once free.
// Throughput: one request per cycle when each gives at most one result and no result
// stalls; a request with two results holds the single result register until both are taken.
// Reset (i_rst_n, synchronous, active low) empties both stages, sets 7-bit mode
// and clears septet phase, carry, held octet and pair flag.
`timescale 1ns / 1ps

module sms_user_data_hex_decoder
    import smsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_data,
    smsd_in_if.sink      i_in,
    smsd_out_if.source   o_out
);

    logic     in_valid;
    t_in_item in_item;
    t_dec_res dec_res;
    logic     out_free;
    logic     fire;

    assign fire = in_valid && out_free;

    smsd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_fire  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    smsd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_item),
        .i_fire     (fire),
        .o_res      (dec_res)
    );

    smsd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_res   (dec_res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

>>> sv/smsd_checker.sv
// Port-level checks of the decoder, attached to the top level by a bind.
// Depends on the top level sms_user_data_hex_decoder.
`timescale 1ns / 1ps

module smsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_char_out,
    input logic       i_run_last
);

    // A stalled result keeps its valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_char_out) && $stable(i_run_last))
        else $error("output payload changed while stalled");

    // Input back-pressure can only come from a result that is waiting.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    // The second result of a request follows right after the first is taken.
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_run_last |=> i_out_valid)
        else $error("second result of a request missing");

    // Reset leaves no result showing.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sms_user_data_hex_decoder smsd_checker u_smsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_out  (o_out.char_out),
    .i_run_last  (o_out.run_last)
);

>>> verif/smsd_checker.sv
// Scoreboard for the SMS user data hex decoder: watches both channels and the mode port.
// Predicts the decoded characters of every accepted request and compares them in order.
// Depends on smsd_pkg and the channel interfaces in smsd_ifs.
`timescale 1ns / 1ps

module smsd_scoreboard
    import smsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  [1:0] i_cfg_data,
    smsd_in_if    i_in_mon,
    smsd_out_if   i_out_mon,
    output int    o_pending,
    output int    o_fail_count
);

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
    } t_char_exp;

    t_char_exp  char_queue[$];

    // Shadow copy of the decoder state.
    t_mode      cur_mode;
    logic [2:0] sept_phase;
    logic [6:0] carry_reg;
    logic [7:0] held_reg;
    logic       half_full;
    int         fails;

    function automatic logic [3:0] hex_digit_value(input logic [7:0] ch);
        logic [7:0] val;
        val = (ch >= CHAR_ZERO && ch <= CHAR_NINE) ? ch - CHAR_ZERO : ch - HEX_ALPHA_OFS;
        return val[3:0];
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic last);
        t_char_exp item;
        item.char_out = ch;
        item.run_last = last;
        char_queue.push_back(item);
    endtask

    task automatic decode_octet(input logic [7:0] hh, input logic [7:0] hl, input logic fin);
        logic [7:0]  octet;
        logic [2:0]  ph;
        logic [15:0] wide;
        logic [7:0]  upper;
        octet = {hex_digit_value(hh), hex_digit_value(hl)};
        case (cur_mode)
            MODE_SEVEN: begin
                ph = (sept_phase == SEPT_BITS) ? 3'd0 : sept_phase;
                wide = ({8'h00, octet} << ph) | {9'h000, carry_reg};
                upper = octet >> (SEPT_BITS - ph);
                carry_reg = upper[6:0];
                if (ph == LAST_PHASE) begin
                    // The seventh octet completes a group: its carry is a full septet.
                    push_char({1'b0, wide[6:0]}, 1'b0);
                    push_char({1'b0, carry_reg}, 1'b1);
                    sept_phase = 3'd0;
                    carry_reg = 7'd0;
                end else begin
                    push_char({1'b0, wide[6:0]}, 1'b1);
                    sept_phase = ph + 3'd1;
                end
            end
            MODE_EIGHT: begin
                push_char(octet, 1'b1);
            end
            MODE_UCS2: begin
                if (half_full) begin
                    push_char(octet, 1'b0);
                    push_char(held_reg, 1'b1);
                    half_full = 1'b0;
                end else begin
                    held_reg = octet;
                    half_full = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (fin) begin
            sept_phase = 3'd0;
            carry_reg = 7'd0;
            held_reg = 8'd0;
            half_full = 1'b0;
        end
    endtask

    task automatic check_char(input logic [7:0] ch, input logic last);
        t_char_exp want;
        if (char_queue.size() == 0) begin
            $error("unexpected result: char_out 0x%02h run_last %0b", ch, last);
            fails++;
        end else begin
            want = char_queue.pop_front();
            if (ch !== want.char_out) begin
                $error("char_out mismatch: expected 0x%02h, actual 0x%02h", want.char_out, ch);
                fails++;
            end
            if (last !== want.run_last) begin
                $error("run_last mismatch: expected %0b, actual %0b", want.run_last, last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode = MODE_SEVEN;
            sept_phase = 3'd0;
            carry_reg = 7'd0;
            held_reg = 8'd0;
            half_full = 1'b0;
            fails = 0;
            char_queue.delete();
        end else begin
            if (i_cfg_we) begin
                cur_mode = t_mode'(i_cfg_data);
            end
            // Results leaving now stem from earlier requests, so compare before predicting.
            if (i_out_mon.valid && i_out_mon.ready) begin
                check_char(i_out_mon.char_out, i_out_mon.run_last);
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_octet(i_in_mon.hex_high, i_in_mon.hex_low, i_in_mon.final_octet);
            end
        end
        o_pending <= char_queue.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/sms_user_data_hex_decoder_tb.sv
// Top of the SMS user data hex decoder testbench: clock, reset, stimulus and verdict.
// Depends on smsd_pkg, smsd_ifs, the decoder RTL and smsd_scoreboard.
`timescale 1ns / 1ps

module sms_user_data_hex_decoder_tb;
    import smsd_pkg::*;

    localparam int RANDOM_ITEMS  = 800;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int LONG_HOLD     = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_data;
    int         pending;
    int         fail_count;
    int         tx_burst;
    int         rx_burst;
    int         rx_taken;
    int         idle_cycles;

    smsd_in_if  in_ch();
    smsd_out_if out_ch();

    sms_user_data_hex_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    smsd_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Random wait before each item, with occasional stretches of back-to-back traffic.
    function automatic int draw_gap(ref int burst);
        int gap;
        if (burst > 0) begin
            burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 19) == 0) begin
                burst = $urandom_range(10, 30);
            end
        end
        return gap;
    endfunction

    function automatic logic [7:0] hex_char();
        logic [7:0] digit;
        digit = 8'($urandom_range(0, 15));
        return (digit < 8'd10) ? CHAR_ZERO + digit : HEX_ALPHA_OFS + digit;
    endfunction

    task automatic send_octet(input logic [7:0] hh, input logic [7:0] hl, input logic fin);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.hex_high    <= hh;
        in_ch.hex_low     <= hl;
        in_ch.final_octet <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drains the decoder and lets it settle, since some requests give no result.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode mode);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Result side: random stalls, plus two long hold-offs that back up the input.
    initial begin
        int wait_cycles;
        rx_burst = 0;
        rx_taken = 0;
        out_ch.ready <= 1'b0;
        forever begin
            if (rx_taken == 200 || rx_taken == 600) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            wait_cycles = draw_gap(rx_burst);
            if (wait_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            rx_taken++;
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_mode mode;
        int    counted;
        int    phase_no;
        int    phase_len;
        int    sent;
        int    msg_len;
        logic  fin;
        logic [7:0] hh;
        logic [7:0] hl;

        tx_burst = 0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= MODE_SEVEN;
        in_ch.valid       <= 1'b0;
        in_ch.hex_high    <= 8'h00;
        in_ch.hex_low     <= 8'h00;
        in_ch.final_octet <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Seven-bit mode straight from reset, one full septet group.
        send_octet("0", "0", 1'b0);
        send_octet("F", "F", 1'b0);
        send_octet("7", "F", 1'b0);
        send_octet("8", "0", 1'b0);
        send_octet("A", "A", 1'b0);
        send_octet("5", "5", 1'b0);
        send_octet("C", "3", 1'b0);
        send_octet("1", "2", 1'b0);
        // Final octet in mid group: leftover carry is padding.
        send_octet("F", "F", 1'b1);
        // Characters that are not hex digits.
        send_octet(8'h00, 8'hFF, 1'b0);
        send_octet("a", "G", 1'b1);
        // Mode changes in mid message keep each mode's own state.
        send_octet("4", "1", 1'b0);
        send_octet("4", "2", 1'b0);
        set_mode(MODE_UCS2);
        send_octet("1", "2", 1'b0);
        set_mode(MODE_SEVEN);
        send_octet("4", "3", 1'b0);
        set_mode(MODE_EIGHT);
        send_octet("0", "0", 1'b0);
        send_octet("F", "F", 1'b0);
        send_octet(8'hFF, 8'h00, 1'b0);
        set_mode(MODE_UCS2);
        send_octet("3", "4", 1'b0);
        send_octet("A", "B", 1'b0);
        send_octet("C", "D", 1'b0);
        // Odd UCS2 length: the lone first half is dropped.
        send_octet("E", "F", 1'b1);
        set_mode(MODE_NONE);
        send_octet("F", "F", 1'b0);
        send_octet("0", "0", 1'b1);
        set_mode(MODE_SEVEN);
        send_octet("2", "0", 1'b1);

        counted  = 0;
        phase_no = 0;
        while (counted < RANDOM_ITEMS) begin
            case (phase_no)
                0:       mode = MODE_UCS2;
                1:       mode = MODE_NONE;
                2:       mode = MODE_EIGHT;
                3:       mode = MODE_SEVEN;
                default: mode = t_mode'($urandom_range(0, 3));
            endcase
            set_mode(mode);
            phase_len = (mode == MODE_NONE) ? 12 : 100;
            sent = 0;
            while (sent < phase_len) begin
                msg_len = $urandom_range(1, 16);
                for (int k = 0; k < msg_len; k++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        hh = 8'($urandom_range(0, 255));
                        hl = 8'($urandom_range(0, 255));
                    end else begin
                        hh = hex_char();
                        hl = hex_char();
                    end
                    // Now and then a message runs on without its final octet.
                    fin = (k == msg_len - 1) && ($urandom_range(0, 9) != 0);
                    send_octet(hh, hl, fin);
                    sent++;
                    if (mode != MODE_NONE) begin
                        counted++;
                    end
                end
            end
            phase_no++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
